// ===== hdl/hre_pkg.sv =====
// shared constants for the highlight recovery and exposure block
`default_nettype none
package hre_pkg;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_CLIP_LEVEL    = 1'b0,
		CFG_EXPOSURE_GAIN = 1'b1
	} cfg_index_t;

	localparam int REG_BITS       = 16;
	localparam int GAIN_FRAC_BITS = 12;

	// gain reset is 2^0.7 in q4.12
	localparam logic [REG_BITS-1:0] GAIN_RESET = 16'd6654;

endpackage
`default_nettype wire

// ===== hdl/hre_stream_if.sv =====
// pixel stream interfaces for the input and output channels
`default_nettype none
interface hre_pix_in_if #(
	parameter int CHANNEL_BITS = 16
);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red_in;
	logic [CHANNEL_BITS-1:0] green_in;
	logic [CHANNEL_BITS-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface hre_pix_out_if #(
	parameter int CHANNEL_BITS = 16
);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red_out;
	logic [CHANNEL_BITS-1:0] green_out;
	logic [CHANNEL_BITS-1:0] blue_out;

	modport source (output valid, output red_out, output green_out, output blue_out, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out, output ready);
endinterface
`default_nettype wire

// ===== hdl/highlight_recovery_exposure.sv =====
// highlight recovery by clip ratio followed by exposure gain, one pixel per clock
//
// One rgb pixel goes in per transaction and one comes out. Channels at or above
// clip_level count as clipped; when one or two channels are clipped and the
// brightest unclipped channel (the reference) is at least 0.01, each clipped
// channel becomes floor(channel * clip_level / reference), capped at 1.5 times
// clip_level. All channels are then scaled by exposure_gain (q4.12), rounded half
// up and saturated. The datapath is a stall-able pipeline of CHANNEL_BITS + 7
// stages (23 at the default width): input decode, clip product, divider setup,
// one restoring division step per quotient bit (CHANNEL_BITS + 1 of them), ratio
// select, gain multiply, round and saturate. A new pixel is taken every clock
// unless the output stalls; each stage moves on when it is empty or its successor
// moves, so bubbles close up while the output waits. Configuration must be written
// only while the pipeline is empty; the user must keep to it, the block does not.
`default_nettype none
module highlight_recovery_exposure
	import hre_pkg::*;
#(
	parameter int CHANNEL_BITS  = 16,
	parameter int FRACTION_BITS = 14
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	hre_pix_in_if.sink               pix_in,
	hre_pix_out_if.source            pix_out,
	input  wire logic                cfg_we,
	input  wire logic [0:0]          cfg_index,
	input  wire logic [REG_BITS-1:0] cfg_data
);

	localparam int CB = CHANNEL_BITS;
	localparam int QB = CB + 1;        // quotient bits, enough to hold the cap
	localparam int NW = 2 * CB;        // channel times clip level
	localparam int PW = QB + REG_BITS; // gained product

	localparam logic [63:0] ONE_Q      = 64'd1 << FRACTION_BITS;
	localparam logic [63:0] DARK_LIMIT = (ONE_Q + 64'd50) / 64'd100;
	localparam logic [63:0] CLIP_RESET = (ONE_Q * 64'd95 + 64'd50) / 64'd100;
	localparam logic [CB-1:0] OUT_MASK =
		(CB > REG_BITS) ? CB'({REG_BITS{1'b1}}) : {CB{1'b1}};

	typedef struct packed {
		logic [2:0][CB-1:0] ch;
		logic [2:0]         clipped;
		logic [CB-1:0]      ref_lvl;
		logic               rec;
	} side_t;

	typedef struct packed {
		logic          ovf;
		logic [CB-1:0] rem;
		logic [QB-1:0] lo;
		logic [QB-1:0] quo;
	} div_lane_t;

	// configuration registers
	logic [CB-1:0]       clip_q;
	logic [REG_BITS-1:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= CB'(CLIP_RESET);
			gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_CLIP_LEVEL:    clip_q <= CB'(cfg_data);
				CFG_EXPOSURE_GAIN: gain_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	// per-stage valid and advance
	logic v_s1, v_s2, v_s3, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s5, en_s6, en_s7;
	logic v_s4 [QB];
	logic en_s4 [QB];

	assign en_s7 = !v_s7 || pix_out.ready;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s3 = !v_s3 || en_s4[0];
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign pix_in.ready = en_s1;

	// stage 1: clip flags, reference and recovery decision
	logic [2:0][CB-1:0] chan_c;
	logic [2:0]         clip_c;
	logic [CB-1:0]      ref_c;
	logic               rec_c;

	assign chan_c = {pix_in.blue_in, pix_in.green_in, pix_in.red_in};

	always_comb begin
		ref_c = '0;
		for (int k = 0; k < 3; k++) begin
			clip_c[k] = chan_c[k] >= clip_q;
			if (!clip_c[k] && chan_c[k] > ref_c) begin
				ref_c = chan_c[k];
			end
		end
		// exactly one or two clipped, and a usable reference
		rec_c = (|clip_c) && !(&clip_c) && (64'(ref_c) >= DARK_LIMIT) && (ref_c != '0);
	end

	side_t side_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			side_s1.ch      <= chan_c;
			side_s1.clipped <= clip_c;
			side_s1.ref_lvl <= ref_c;
			side_s1.rec     <= rec_c;
		end
	end

	// stage 2: dividend = channel * clip level
	side_t              side_s2;
	logic [2:0][NW-1:0] num_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			side_s2 <= side_s1;
			for (int k = 0; k < 3; k++) begin
				num_s2[k] <= NW'(side_s1.ch[k]) * NW'(clip_q);
			end
		end
	end

	// stage 3: divider setup, quotient too wide for QB bits saturates to the cap
	side_t                side_s3;
	div_lane_t [2:0]      lane_s3;
	div_lane_t [2:0]      lane_init_c;
	logic [2:0][NW-1:0]   hi_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			hi_c[k]            = num_s2[k] >> QB;
			lane_init_c[k].ovf = hi_c[k] >= NW'(side_s2.ref_lvl);
			lane_init_c[k].rem = hi_c[k][CB-1:0];
			lane_init_c[k].lo  = num_s2[k][QB-1:0];
			lane_init_c[k].quo = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			side_s3 <= side_s2;
			lane_s3 <= lane_init_c;
		end
	end

	// stage 4 group: one restoring division step per stage, msb first
	side_t           side_s4 [QB];
	div_lane_t [2:0] lane_s4 [QB];

	for (genvar d = 0; d < QB; d++) begin : g_div
		side_t              side_in;
		div_lane_t [2:0]    lane_in;
		logic               v_in;
		div_lane_t [2:0]    lane_nx;
		logic [2:0][CB:0]   trial;
		logic [2:0][CB:0]   diff;
		logic [2:0]         ge;

		if (d == 0) begin : g_first
			assign side_in = side_s3;
			assign lane_in = lane_s3;
			assign v_in    = v_s3;
		end else begin : g_next
			assign side_in = side_s4[d-1];
			assign lane_in = lane_s4[d-1];
			assign v_in    = v_s4[d-1];
		end

		if (d == QB - 1) begin : g_last
			assign en_s4[d] = !v_s4[d] || en_s5;
		end else begin : g_mid
			assign en_s4[d] = !v_s4[d] || en_s4[d+1];
		end

		always_comb begin
			for (int k = 0; k < 3; k++) begin
				trial[k]       = {lane_in[k].rem, lane_in[k].lo[QB-1]};
				diff[k]        = trial[k] - {1'b0, side_in.ref_lvl};
				ge[k]          = trial[k] >= {1'b0, side_in.ref_lvl};
				lane_nx[k].ovf = lane_in[k].ovf;
				lane_nx[k].rem = ge[k] ? diff[k][CB-1:0] : trial[k][CB-1:0];
				lane_nx[k].lo  = {lane_in[k].lo[QB-2:0], 1'b0};
				lane_nx[k].quo = {lane_in[k].quo[QB-2:0], ge[k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s4[d] <= 1'b0;
			end else if (en_s4[d]) begin
				v_s4[d] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en_s4[d]) begin
				side_s4[d] <= side_in;
				lane_s4[d] <= lane_nx;
			end
		end
	end

	// stage 5: pick recovered or original channel, cap at 1.5 * clip
	logic [QB-1:0]      cap_c;
	logic [2:0][QB-1:0] val_c;
	logic [2:0][QB-1:0] val_s5;

	assign cap_c = {1'b0, clip_q} + {2'b00, clip_q[CB-1:1]};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (side_s4[QB-1].rec && side_s4[QB-1].clipped[k]) begin
				if (lane_s4[QB-1][k].ovf || lane_s4[QB-1][k].quo > cap_c) begin
					val_c[k] = cap_c;
				end else begin
					val_c[k] = lane_s4[QB-1][k].quo;
				end
			end else begin
				val_c[k] = {1'b0, side_s4[QB-1].ch[k]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			val_s5 <= val_c;
		end
	end

	// stage 6: exposure gain product
	logic [2:0][PW-1:0] prod_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			for (int k = 0; k < 3; k++) begin
				prod_s6[k] <= PW'(val_s5[k]) * PW'(gain_q);
			end
		end
	end

	// stage 7: round half up, drop gain fraction, saturate
	logic [2:0][PW:0]                  rnd_c;
	logic [2:0][PW-GAIN_FRAC_BITS:0]   shr_c;
	logic [2:0][CB-1:0]                sat_c;
	logic [2:0][CB-1:0]                out_s7;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rnd_c[k] = {1'b0, prod_s6[k]} + (PW+1)'(1 << (GAIN_FRAC_BITS - 1));
			shr_c[k] = rnd_c[k][PW:GAIN_FRAC_BITS];
			if (|shr_c[k][PW-GAIN_FRAC_BITS:CB]) begin
				sat_c[k] = {CB{1'b1}};
			end else begin
				sat_c[k] = shr_c[k][CB-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			for (int k = 0; k < 3; k++) begin
				out_s7[k] <= sat_c[k] & OUT_MASK;
			end
		end
	end

	// valid bits for the fixed stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix_in.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s5) v_s5 <= v_s4[QB-1];
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	assign pix_out.valid     = v_s7;
	assign pix_out.red_out   = out_s7[0];
	assign pix_out.green_out = out_s7[1];
	assign pix_out.blue_out  = out_s7[2];

endmodule
`default_nettype wire

// ===== test/highlight_recovery_exposure_tb.sv =====
// self-checking testbench for highlight recovery with exposure gain
`default_nettype none
module highlight_recovery_exposure_tb;
	import hre_pkg::*;

	localparam int CHANNEL_BITS  = 16;
	localparam int FRACTION_BITS = 14;
	localparam longint unsigned CHAN_MAX = (64'd1 << CHANNEL_BITS) - 1;
	// 0.01 and 0.95 in q2.14, rounded to nearest
	localparam int DARK_LIMIT = ((1 << FRACTION_BITS) + 50) / 100;
	localparam logic [REG_BITS-1:0] CLIP_RESET =
		REG_BITS'(((1 << FRACTION_BITS) * 95 + 50) / 100);
	// pipeline is CHANNEL_BITS + 7 deep, the tail wait covers it with margin
	localparam int TAIL_CYCLES    = 2 * (CHANNEL_BITS + 7);
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 10;
	localparam int PHASE_ITEMS    = 100;
	localparam int FLOOD_ITEMS    = 120;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
	} pixel_t;

	// output-side ready patterns
	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_THREE_OF_FOUR,
		RX_SPARSE
	} rx_pattern_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [0:0]          cfg_index;
	logic [REG_BITS-1:0] cfg_data;

	hre_pix_in_if  #(.CHANNEL_BITS(CHANNEL_BITS)) pix_in_bus ();
	hre_pix_out_if #(.CHANNEL_BITS(CHANNEL_BITS)) pix_out_bus ();

	highlight_recovery_exposure #(
		.CHANNEL_BITS (CHANNEL_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix_in_bus),
		.pix_out  (pix_out_bus),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow copy of the two registers, used when a pixel is accepted
	logic [REG_BITS-1:0] clip_now;
	logic [REG_BITS-1:0] gain_now;

	// pixels the block still owes us, oldest first
	pixel_t recovered_q[$];

	int          mismatch_count = 0;
	int          idle_cycles    = 0;
	int unsigned burst_left     = 0;
	// set by the flood test, cleared by the receiver once its hold-off is over
	bit          stall_request  = 1'b0;

	// expected output pixel: clip-ratio recovery, then gain with round half up and saturate
	function automatic pixel_t recover_and_gain(input pixel_t px, input logic [REG_BITS-1:0] clip,
			input logic [REG_BITS-1:0] gain);
		longint unsigned ch [3];
		longint unsigned lim, amp, anchor, cap, scaled, gained;
		int clipped;
		pixel_t res;
		lim = 64'(clip);
		amp = 64'(gain);
		ch[0] = 64'(px.red);
		ch[1] = 64'(px.green);
		ch[2] = 64'(px.blue);
		clipped = 0;
		anchor = 0;
		// anchor is the brightest channel still below the clip level
		for (int k = 0; k < 3; k++) begin
			if (ch[k] >= lim)
				clipped++;
			else if (ch[k] > anchor)
				anchor = ch[k];
		end
		// recovery only for partial clipping with a reference that is not too dark
		if (clipped >= 1 && clipped <= 2 && anchor >= DARK_LIMIT) begin
			cap = lim + (lim >> 1);
			for (int k = 0; k < 3; k++) begin
				if (ch[k] >= lim) begin
					scaled = (ch[k] * lim) / anchor;
					ch[k] = (scaled > cap) ? cap : scaled;
				end
			end
		end
		for (int k = 0; k < 3; k++) begin
			gained = (ch[k] * amp + (64'd1 << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
			ch[k] = (gained > CHAN_MAX) ? CHAN_MAX : gained;
		end
		res.red   = ch[0][CHANNEL_BITS-1:0];
		res.green = ch[1][CHANNEL_BITS-1:0];
		res.blue  = ch[2][CHANNEL_BITS-1:0];
		return res;
	endfunction

	// channel values clustered where the decisions are made: around clip and the dark limit
	function automatic logic [CHANNEL_BITS-1:0] random_channel(input logic [REG_BITS-1:0] clip);
		int v;
		case ($urandom_range(0, 6))
			0: v = $urandom_range(0, 32'(CHAN_MAX));
			1: v = (clip == 0) ? 0 : $urandom_range(0, clip - 1);
			2: v = $urandom_range(clip, 32'(CHAN_MAX));
			3: v = int'(clip) + $urandom_range(0, 4) - 2;
			4: v = $urandom_range(0, 200);
			5: v = $urandom_range(0, 1) ? int'(CHAN_MAX) : 0;
			default: v = $urandom_range(DARK_LIMIT - 14, DARK_LIMIT + 16);
		endcase
		if (v < 0)
			v = 0;
		else if (v > CHAN_MAX)
			v = int'(CHAN_MAX);
		return v[CHANNEL_BITS-1:0];
	endfunction

	// offer one pixel and hold it until the block takes it; valid stays high afterwards
	task automatic send_pixel(input pixel_t px);
		pix_in_bus.valid    <= 1'b1;
		pix_in_bus.red_in   <= px.red;
		pix_in_bus.green_in <= px.green;
		pix_in_bus.blue_in  <= px.blue;
		do
			@(posedge clk);
		while (!pix_in_bus.ready);
		recovered_q.push_back(recover_and_gain(px, clip_now, gain_now));
	endtask

	// bursts of random length, separated by random gaps (sometimes none)
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap != 0) begin
				pix_in_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_rgb(input int r, input int g, input int b);
		pixel_t px;
		px.red   = r[CHANNEL_BITS-1:0];
		px.green = g[CHANNEL_BITS-1:0];
		px.blue  = b[CHANNEL_BITS-1:0];
		send_pixel(px);
		pace_sender();
	endtask

	task automatic send_random_pixel();
		pixel_t px;
		px.red   = random_channel(clip_now);
		px.green = random_channel(clip_now);
		px.blue  = random_channel(clip_now);
		send_pixel(px);
	endtask

	// stop offering and wait until every owed pixel has come out
	task automatic settle_pipeline();
		pix_in_bus.valid <= 1'b0;
		while (recovered_q.size() != 0)
			@(posedge clk);
	endtask

	// both registers in back-to-back writes, only while the pipeline is empty
	task automatic apply_settings(input logic [REG_BITS-1:0] clip, input logic [REG_BITS-1:0] gain);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CLIP_LEVEL;
		cfg_data  <= clip;
		@(posedge clk);
		cfg_index <= CFG_EXPOSURE_GAIN;
		cfg_data  <= gain;
		@(posedge clk);
		cfg_we   <= 1'b0;
		clip_now = clip;
		gain_now = gain;
	endtask

	// reset values, then the special cases of recovery at default clip and gain
	task automatic test_reset_defaults();
		send_rgb(0, 0, 0);
		send_rgb(65535, 65535, 65535);   // all three clipped, passes to gain
		send_rgb(8000, 4000, 2000);      // nothing clipped
		send_rgb(20000, 8000, 3000);     // one clipped
		send_rgb(16000, 15565, 5000);    // two clipped, one exactly at clip
		send_rgb(15564, 15564, 15564);   // one below clip everywhere
		send_rgb(20000, 163, 100);       // reference just under the dark limit
		send_rgb(20000, 164, 0);         // reference exactly at the dark limit
		send_rgb(65535, 0, 200);         // huge ratio, capped at 1.5 clip
		send_rgb(0, 65535, 9000);
		send_rgb(30000, 12000, 30000);
		send_rgb(65535, 65535, 15564);   // two clipped, ratio near one
		settle_pipeline();
	endtask

	// register extremes: max clip with max gain, zero gain, zero clip with unity gain
	task automatic test_register_extremes();
		apply_settings(16'hFFFF, 16'hFFFF);
		send_rgb(65535, 65535, 65535);
		send_rgb(65534, 1, 0);           // gained overflow saturates
		send_rgb(1, 1, 1);
		send_rgb(65535, 40000, 0);
		settle_pipeline();
		apply_settings(16'd1, 16'd0);
		send_rgb(65535, 0, 0);
		send_rgb(0, 0, 0);
		send_rgb(12345, 678, 9);
		settle_pipeline();
		// zero clip level: every channel counts as clipped
		apply_settings(16'd0, 16'd4096);
		send_rgb(65535, 1234, 0);
		send_rgb(0, 0, 0);
		send_rgb(40000, 20000, 100);
		settle_pipeline();
	endtask

	// output held off for a long stretch while input keeps coming, so the pipe backs up
	task automatic test_output_backpressure();
		apply_settings(CLIP_RESET, GAIN_RESET);
		stall_request = 1'b1;
		repeat (FLOOD_ITEMS)
			send_random_pixel();
		settle_pipeline();
	endtask

	// random pixels under a series of settings, extremes among them
	task automatic test_random_settings();
		logic [REG_BITS-1:0] clip_set [6];
		logic [REG_BITS-1:0] gain_set [6];
		clip_set[0] = CLIP_RESET;
		gain_set[0] = GAIN_RESET;
		clip_set[1] = REG_BITS'($urandom_range(8000, 20000));
		gain_set[1] = REG_BITS'($urandom_range(2048, 16384));
		clip_set[2] = 16'hFFFF;
		gain_set[2] = REG_BITS'($urandom_range(0, 16'hFFFF));
		clip_set[3] = 16'd1;
		gain_set[3] = REG_BITS'($urandom_range(0, 16'hFFFF));
		clip_set[4] = REG_BITS'($urandom_range(1, 16'hFFFF));
		gain_set[4] = 16'hFFFF;
		clip_set[5] = REG_BITS'($urandom_range(1, 16'hFFFF));
		gain_set[5] = REG_BITS'($urandom_range(0, 16'hFFFF));
		for (int p = 0; p < 6; p++) begin
			apply_settings(clip_set[p], gain_set[p]);
			repeat (PHASE_ITEMS) begin
				send_random_pixel();
				pace_sender();
			end
			settle_pipeline();
		end
	endtask

	// compare every output transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		pixel_t want;
		pixel_t got;
		if (arst_n && pix_out_bus.valid && pix_out_bus.ready) begin
			got = {pix_out_bus.red_out, pix_out_bus.green_out, pix_out_bus.blue_out};
			if (recovered_q.size() == 0) begin
				if (mismatch_count < MAX_REPORTS)
					$display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $realtime,
						got.red, got.green, got.blue);
				mismatch_count++;
			end else begin
				want = recovered_q.pop_front();
				if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
					if (mismatch_count < MAX_REPORTS)
						$display("%0t: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
							$realtime, want.red, want.green, want.blue,
							got.red, got.green, got.blue);
					mismatch_count++;
				end
			end
		end
	end

	// ends the run if neither side moves a transaction for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_in_bus.valid && pix_in_bus.ready) || (pix_out_bus.valid && pix_out_bus.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// receiver: switches among ready patterns, with a long hold-off on request
	initial begin : receiver
		rx_pattern_t pattern;
		int unsigned pattern_left;
		int unsigned cyc;
		pix_out_bus.ready <= 1'b0;
		pattern = RX_OPEN;
		pattern_left = 0;
		cyc = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			cyc++;
			if (stall_request) begin
				pix_out_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				stall_request = 1'b0;
			end else begin
				if (pattern_left == 0) begin
					pattern = rx_pattern_t'($urandom_range(0, 3));
					pattern_left = $urandom_range(30, 150);
				end
				pattern_left--;
				case (pattern)
					RX_OPEN:          pix_out_bus.ready <= 1'b1;
					RX_COIN:          pix_out_bus.ready <= 1'($urandom_range(0, 1));
					RX_THREE_OF_FOUR: pix_out_bus.ready <= (cyc % 4) != 0;
					default:          pix_out_bus.ready <= ($urandom_range(0, 9) < 2);
				endcase
			end
		end
	end

	initial begin
		arst_n              <= 1'b0;
		pix_in_bus.valid    <= 1'b0;
		pix_in_bus.red_in   <= '0;
		pix_in_bus.green_in <= '0;
		pix_in_bus.blue_in  <= '0;
		cfg_we              <= 1'b0;
		cfg_index           <= CFG_CLIP_LEVEL;
		cfg_data            <= '0;
		clip_now = CLIP_RESET;
		gain_now = GAIN_RESET;
		burst_left = $urandom_range(1, 40);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_output_backpressure();
		test_random_settings();

		// everything is back; give any stray output time to show up
		settle_pipeline();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && recovered_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
